// ----- hdl/itda_pkg.sv -----
// Shared constants and types for the integer to decimal ASCII formatter.
`timescale 1ns / 1ps
`default_nettype none

package itda_pkg;

    // Input word and decimal digit chain sizes
    localparam int WORD_W     = 32;
    localparam int NUM_DIGITS = 10;
    localparam int DIGIT_W    = 4;
    localparam int BIT_CNT_W  = $clog2(WORD_W);
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);
    localparam int CHAR_W     = 8;

    // ASCII codes
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

    // Control shared by every cell of the digit chain
    typedef struct packed {
        logic clr;   // clear the digit at the start of a request
        logic dbl;   // add-3 adjust and shift one binary bit in
        logic dig;   // shift a whole digit toward the top of the chain
    } t_cell_ctl;

endpackage

`default_nettype wire

// ----- hdl/itda_bcd_cell.sv -----
// One decimal digit cell of the shift-and-add-3 conversion chain.
`timescale 1ns / 1ps
`default_nettype none

module itda_bcd_cell (
    input  wire                            i_clk,
    input  wire  itda_pkg::t_cell_ctl      i_ctl,
    input  wire                            i_bit,
    input  wire  [itda_pkg::DIGIT_W-1:0]   i_digit,
    output logic                           o_bit,
    output logic [itda_pkg::DIGIT_W-1:0]   o_digit
);

    logic [itda_pkg::DIGIT_W-1:0] r_digit;
    logic [itda_pkg::DIGIT_W-1:0] w_adj;
    logic [itda_pkg::DIGIT_W-1:0] n_digit;

    // Add 3 when the digit would overflow past 9 after doubling
    always_comb begin
        w_adj = (r_digit >= 4'd5) ? (r_digit + 4'd3) : r_digit;
    end

    // Select the next digit value
    always_comb begin
        n_digit = r_digit;
        if (i_ctl.clr) begin
            n_digit = '0;
        end else if (i_ctl.dbl) begin
            n_digit = {w_adj[itda_pkg::DIGIT_W-2:0], i_bit};
        end else if (i_ctl.dig) begin
            n_digit = i_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

    // Hand the carry bit and the digit to the next cell up
    assign o_bit   = w_adj[itda_pkg::DIGIT_W-1];
    assign o_digit = r_digit;

endmodule

`default_nettype wire

// ----- hdl/int_to_decimal_ascii.sv -----
// Top level of the integer to decimal ASCII formatter.
// Usage:
//   Slave channel: s_axis_tdata carries the 32-bit word, s_axis_tuser the mode
//   (0 reads the word as two's complement, 1 as unsigned). A request is taken
//   when s_axis_tvalid and s_axis_tready are both high.
//   Master channel: one ASCII character per transfer on m_axis_tdata, most
//   significant digit first, with a leading '-' for negative signed words.
//   m_axis_tlast marks the final character of the number.
//   A request runs through a chain of ten BCD digit cells (one binary bit per
//   cycle), then finds the leading digit (one leading-zero shift per cycle),
//   then sends one character per cycle while the receiver keeps tready high.
//   One request is handled at a time; s_axis_tready is high only while idle.
//   The last character sits in an output register, so the next request is
//   taken while it waits. When the receiver stalls, the character holds on
//   m_axis_tdata and the chain holds its digits.
//   Reset (synchronous, active low) returns to idle and drops any pending
//   character.
`timescale 1ns / 1ps
`default_nettype none

module int_to_decimal_ascii (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire  [itda_pkg::WORD_W-1:0]   s_axis_tdata,  // [31:0] value
    input  wire                           s_axis_tuser,  // [0] mode
    output logic                          m_axis_tvalid,
    input  wire                           m_axis_tready,
    output logic [itda_pkg::CHAR_W-1:0]   m_axis_tdata,  // [7:0] char_out
    output logic                          m_axis_tlast   // last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SKIP = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]                        r_state;
    logic [1:0]                        n_state;
    logic [itda_pkg::WORD_W-1:0]       r_mag;
    logic [itda_pkg::BIT_CNT_W-1:0]    r_cnt;
    logic [itda_pkg::DIG_CNT_W-1:0]    r_left;
    logic                              r_neg;
    logic                              r_m_valid;
    logic [itda_pkg::CHAR_W-1:0]       r_m_data;
    logic                              r_m_last;

    logic                              w_accept;
    logic                              w_neg_in;
    logic                              w_out_free;
    logic                              w_load;
    logic                              w_load_digit;
    logic                              w_skip;
    logic                              w_last_char;
    itda_pkg::t_cell_ctl               w_ctl;
    logic [itda_pkg::DIGIT_W-1:0]      w_top;
    logic                              w_bit   [0:itda_pkg::NUM_DIGITS];
    logic [itda_pkg::DIGIT_W-1:0]      w_digit [0:itda_pkg::NUM_DIGITS];

    // Handshake and control decode
    always_comb begin
        w_accept     = s_axis_tvalid && s_axis_tready;
        w_neg_in     = !s_axis_tuser && s_axis_tdata[itda_pkg::WORD_W-1];
        w_out_free   = !r_m_valid || m_axis_tready;
        w_load       = (r_state == ST_EMIT) && w_out_free;
        w_load_digit = w_load && !r_neg;
        w_last_char  = (r_left == itda_pkg::DIG_CNT_W'(1));
        w_skip       = (r_state == ST_SKIP) && (w_top == '0) && !w_last_char;
        w_ctl.clr    = w_accept;
        w_ctl.dbl    = (r_state == ST_CONV);
        w_ctl.dig    = w_skip || w_load_digit;
    end

    assign s_axis_tready = (r_state == ST_IDLE);

    // Digit chain: binary bits enter at cell 0, digits leave at the top cell
    assign w_bit[0]   = r_mag[itda_pkg::WORD_W-1];
    assign w_digit[0] = '0;
    assign w_top      = w_digit[itda_pkg::NUM_DIGITS];

    for (genvar g = 0; g < itda_pkg::NUM_DIGITS; g++) begin : g_cell
        itda_bcd_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_bit   (w_bit[g]),
            .i_digit (w_digit[g]),
            .o_bit   (w_bit[g+1]),
            .o_digit (w_digit[g+1])
        );
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_CONV;
            end
            ST_CONV: begin
                if (r_cnt == '0) n_state = ST_SKIP;
            end
            ST_SKIP: begin
                if (!w_skip) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_load_digit && w_last_char) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Magnitude, sign and counters
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mag <= w_neg_in ? (~s_axis_tdata + itda_pkg::WORD_W'(1)) : s_axis_tdata;
            r_neg <= w_neg_in;
            r_cnt <= itda_pkg::BIT_CNT_W'(itda_pkg::WORD_W - 1);
        end else if (r_state == ST_CONV) begin
            r_mag <= {r_mag[itda_pkg::WORD_W-2:0], 1'b0};
            r_cnt <= r_cnt - itda_pkg::BIT_CNT_W'(1);
        end else if (w_load && r_neg) begin
            r_neg <= 1'b0;
        end
        if (r_state == ST_CONV) begin
            r_left <= itda_pkg::DIG_CNT_W'(itda_pkg::NUM_DIGITS);
        end else if (w_ctl.dig) begin
            r_left <= r_left - itda_pkg::DIG_CNT_W'(1);
        end
    end

    // Output register: minus sign first, then digits
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (r_neg) begin
                r_m_data <= itda_pkg::ASCII_MINUS;
                r_m_last <= 1'b0;
            end else begin
                r_m_data <= itda_pkg::ASCII_ZERO + itda_pkg::CHAR_W'(w_top);
                r_m_last <= w_last_char;
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;

`ifndef SYNTH
    // Conversion never carries out of the top digit
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CONV) |-> !w_bit[itda_pkg::NUM_DIGITS])
        else $error("digit chain overflow");

    // Conversion ends after the bit count runs out
    a_conv_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CONV && r_cnt == '0) |=> (r_state == ST_SKIP))
        else $error("conversion did not end on time");

    // Digits at the top of the chain are decimal while emitting
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (w_top <= 4'd9 && r_left != '0))
        else $error("bad digit or digit count while emitting");

    // The last character returns the block to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load_digit && w_last_char) |=> (r_state == ST_IDLE && m_axis_tlast))
        else $error("last character did not end the request");
`endif

endmodule

`default_nettype wire
